>>> sv/cts_pkg.sv
// Shared types and constants for the cooldown task scheduler.
// Used by the core and by its port checker; depends on nothing.
package cts_pkg;

  localparam int NUM_LABELS       = 26;
  localparam int LABEL_W          = 5;
  localparam int COUNT_WIDTH      = 16;
  localparam int SLOT_COUNT_WIDTH = 20;
  localparam int GAP_W            = 8;
  localparam int OUT_COUNT_W      = 20;
  localparam int KIND_W           = 2;

  // Compare tree size: leaves padded up to a power of two.
  localparam int TREE_LEVELS = 5;
  localparam int TREE_LEAVES = 32;

  localparam logic [COUNT_WIDTH-1:0]      COUNT_MAX = '1;
  localparam logic [SLOT_COUNT_WIDTH-1:0] SLOTS_MAX = '1;

  // Item functions.
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_ISSUE = 1'b1;

  // Slot kinds.
  localparam logic [KIND_W-1:0] SLOT_TASK  = 2'd0;
  localparam logic [KIND_W-1:0] SLOT_IDLE  = 2'd1;
  localparam logic [KIND_W-1:0] SLOT_EMPTY = 2'd2;

  typedef struct packed {
    logic               func;
    logic [LABEL_W-1:0] task_label;
  } in_word_t;

  typedef struct packed {
    logic [KIND_W-1:0]      slot_kind;
    logic [LABEL_W-1:0]     slot_label;
    logic                   all_finished;
    logic [OUT_COUNT_W-1:0] interval_count;
  } out_word_t;

endpackage

>>> sv/cooldown_task_scheduler_core.sv
// Cooldown task scheduler core: per-label pending counts and cooldowns with a
// greedy largest-count issue arbiter. Depends on cts_pkg.
//
// The block takes one word per clock on the input channel and, when not held
// back by the output side, sustains one word per cycle in either mode. Each
// word is held first in the input register, and an issue word then leaves
// through the result register.
// Add words update the pending count of their label and produce no result;
// an add with a label beyond the last one is dropped. Issue words pick the
// eligible label (pending count above zero, cooldown zero) with the largest
// count, the higher label winning a tie, and report a task slot, an idle slot
// when work is pending but everything is cooling down, or an empty slot when
// nothing is pending at all. Empty slots neither age the cooldowns nor count
// as slots. The clock rate is set by the 26-way compare tree that finds the
// winner, which together with the count and cooldown updates sits between the
// input register and the state and result registers. Add words never wait
// for the output side, so they flow past a stalled result. The cooldown gap
// register should be written only while the block is idle.
module cooldown_task_scheduler_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [cts_pkg::GAP_W-1:0]      cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cts_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cts_pkg::out_word_t             out_data
);

  // One candidate in the arbiter's compare tree.
  typedef struct packed {
    logic                            vld;
    logic [cts_pkg::COUNT_WIDTH-1:0] cnt;
    logic [cts_pkg::LABEL_W-1:0]     idx;
  } cand_t;

  // Scheduler state.
  logic [cts_pkg::COUNT_WIDTH-1:0]      remaining_count [cts_pkg::NUM_LABELS];
  logic [cts_pkg::GAP_W-1:0]            cooldown_left   [cts_pkg::NUM_LABELS];
  logic [cts_pkg::SLOT_COUNT_WIDTH-1:0] slots_issued;
  logic [cts_pkg::GAP_W-1:0]            cooldown_gap;

  // Input register.
  logic              s1_valid;
  cts_pkg::in_word_t s1_item;

  logic [cts_pkg::COUNT_WIDTH-1:0]      remaining_count_next [cts_pkg::NUM_LABELS];
  logic [cts_pkg::GAP_W-1:0]            cooldown_left_next   [cts_pkg::NUM_LABELS];
  logic [cts_pkg::SLOT_COUNT_WIDTH-1:0] slots_issued_next;
  cts_pkg::out_word_t                   result;

  logic  s1_fire;
  logic  is_issue;
  logic  pending_before;
  logic  pending_after;
  logic  have_slot;
  cand_t tree [cts_pkg::TREE_LEVELS+1][cts_pkg::TREE_LEAVES];
  cand_t winner;

  // The word in the input register moves on when it is an add, or when the
  // result register is free or being emptied in this cycle.
  assign is_issue = (s1_item.func == cts_pkg::FUNC_ISSUE);
  assign s1_fire  = s1_valid && (!is_issue || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_fire;

  // Arbiter: a balanced tree of pairwise compares. The right-hand entry of
  // each pair carries the higher labels, so it wins on equal counts.
  always_comb begin
    tree = '{default: '0};
    for (int i = 0; i < cts_pkg::NUM_LABELS; i++) begin
      tree[0][i].vld = (remaining_count[i] != '0) && (cooldown_left[i] == '0);
      tree[0][i].cnt = remaining_count[i];
      tree[0][i].idx = cts_pkg::LABEL_W'(i);
    end
    for (int l = 1; l <= cts_pkg::TREE_LEVELS; l++) begin
      for (int i = 0; i < cts_pkg::TREE_LEAVES / 2; i++) begin
        if (i < (cts_pkg::TREE_LEAVES >> l)) begin
          if (tree[l-1][2*i+1].vld &&
              (!tree[l-1][2*i].vld || tree[l-1][2*i+1].cnt >= tree[l-1][2*i].cnt)) begin
            tree[l][i] = tree[l-1][2*i+1];
          end else begin
            tree[l][i] = tree[l-1][2*i];
          end
        end
      end
    end
    winner = tree[cts_pkg::TREE_LEVELS][0];
  end

  // Next state and result for the word in the input register.
  always_comb begin
    pending_before = 1'b0;
    for (int k = 0; k < cts_pkg::NUM_LABELS; k++) begin
      pending_before = pending_before | (remaining_count[k] != '0);
    end
    have_slot = is_issue && pending_before;

    slots_issued_next = slots_issued;
    if (have_slot && slots_issued != cts_pkg::SLOTS_MAX) begin
      slots_issued_next = slots_issued + cts_pkg::SLOT_COUNT_WIDTH'(1);
    end

    for (int k = 0; k < cts_pkg::NUM_LABELS; k++) begin
      remaining_count_next[k] = remaining_count[k];
      cooldown_left_next[k]   = cooldown_left[k];
      if (!is_issue) begin
        if (s1_item.task_label == cts_pkg::LABEL_W'(k) &&
            remaining_count[k] != cts_pkg::COUNT_MAX) begin
          remaining_count_next[k] = remaining_count[k] + cts_pkg::COUNT_WIDTH'(1);
        end
      end else if (have_slot) begin
        if (cooldown_left[k] != '0) begin
          cooldown_left_next[k] = cooldown_left[k] - cts_pkg::GAP_W'(1);
        end
        if (winner.vld && winner.idx == cts_pkg::LABEL_W'(k)) begin
          remaining_count_next[k] = remaining_count[k] - cts_pkg::COUNT_WIDTH'(1);
          cooldown_left_next[k]   = cooldown_gap;
        end
      end
    end

    pending_after = 1'b0;
    for (int k = 0; k < cts_pkg::NUM_LABELS; k++) begin
      pending_after = pending_after | (remaining_count_next[k] != '0);
    end

    if (!pending_before) begin
      result.slot_kind = cts_pkg::SLOT_EMPTY;
    end else if (winner.vld) begin
      result.slot_kind = cts_pkg::SLOT_TASK;
    end else begin
      result.slot_kind = cts_pkg::SLOT_IDLE;
    end
    result.slot_label     = (have_slot && winner.vld) ? winner.idx : '0;
    result.all_finished   = !pending_after;
    result.interval_count = slots_issued_next[cts_pkg::OUT_COUNT_W-1:0];
  end

  // Control registers and state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
      slots_issued <= '0;
      cooldown_gap <= '0;
      for (int k = 0; k < cts_pkg::NUM_LABELS; k++) begin
        remaining_count[k] <= '0;
        cooldown_left[k]   <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        cooldown_gap <= cfg_wr_data;
      end

      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire && is_issue) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (s1_fire) begin
        slots_issued <= slots_issued_next;
        for (int k = 0; k < cts_pkg::NUM_LABELS; k++) begin
          remaining_count[k] <= remaining_count_next[k];
          cooldown_left[k]   <= cooldown_left_next[k];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
    if (s1_fire && is_issue) begin
      out_data <= result;
    end
  end

endmodule

>>> sv/cts_checker.sv
// Port-level checker for the cooldown task scheduler core, bound to each core instance.
// Depends on cts_pkg and on the port list of cooldown_task_scheduler_core.
module cts_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input cts_pkg::out_word_t out_data
);

  // A held result word stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  // Only a task slot carries a label.
  a_label_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.slot_kind != cts_pkg::SLOT_TASK |-> out_data.slot_label == '0)
    else $error("label reported on a slot without a task");

  // An empty slot always reports that all work is finished.
  a_empty_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.slot_kind == cts_pkg::SLOT_EMPTY |-> out_data.all_finished)
    else $error("empty slot without finished flag");

  // The input is only held back by a result word that is itself held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result side was free");

endmodule

bind cooldown_task_scheduler_core cts_checker u_cts_checker (.*);
